// File: sv/nlt_pkg.sv
// Package with shared types and constants of the node liveness table.
`default_nettype none
package nlt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int DIV_W = 36;

	localparam logic [15:0] MS_PER_MIN = 16'd60000;
	localparam logic [31:0] MIN_MARGIN_MS = 32'd120000;
	localparam logic [4:0] DIV_TEN = 5'd10;

	typedef enum logic [1:0] {
		MODE_HEARD = 2'd0,
		MODE_INTERVAL = 2'd1,
		MODE_PROFILE = 2'd2,
		MODE_SCAN = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_OK = 3'd0,
		EV_ADDED = 3'd1,
		EV_BACK = 3'd2,
		EV_FULL = 3'd3,
		EV_IGNORED = 3'd4,
		EV_LOST = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		CFG_DEFAULT_TIMEOUT = 3'd0,
		CFG_MIN_INTERVAL = 3'd1,
		CFG_MAX_INTERVAL = 3'd2,
		CFG_MAX_TIMEOUT = 3'd3,
		CFG_MIN_GAP = 3'd4,
		CFG_STALE_FACTOR = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_DIV,
		S_REC1,
		S_REC2,
		S_REC3,
		S_REC4,
		S_RESULT,
		S_SCAN,
		S_SCAN_END
	} state_t;

	// Status of the divide-by-ten unit.
	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: sv/node_liveness_table_unit.sv
// Top level of the node liveness table with its sequencer and entry storage.
`default_nettype none
// Tracks up to 16 remote nodes. Each transaction walks the table one entry per
// cycle, but a scan holds on a lost entry while the result side stalls. An item
// may recompute the timeout, and before that may average a cadence sample
// through the shift-and-add divide-by-ten unit. s_tready is high only between
// items. The results go out through a single output register; lost-node events
// of a scan are held one deep so that tlast marks the final one.
module node_liveness_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// node_id[7:0], now_ms[39:8], interval_min[55:40], aon_flag[56]
	input  logic [63:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_node[7:0], event_res[10:8], node_timeout_ms[42:11],
	// node_interval_min[53:43], node_cycle_ms[85:54]
	output logic [87:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import nlt_pkg::*;

	// Configuration registers.
	logic [31:0] default_to_q, max_to_q, min_gap_q;
	logic [10:0] min_ival_q, max_ival_q;
	logic [4:0] stale_q;

	// Entry storage.
	logic [7:0]  e_node_q [TABLE_DEPTH];
	logic [31:0] e_ls_q [TABLE_DEPTH];
	logic [10:0] e_ival_q [TABLE_DEPTH];
	logic [31:0] e_cycle_q [TABLE_DEPTH];
	logic [31:0] e_to_q [TABLE_DEPTH];
	logic        e_act_q [TABLE_DEPTH];
	logic        e_aon_q [TABLE_DEPTH];
	logic [CNT_W-1:0] used_q;

	// Sequencer state and item registers.
	state_t state_q, state_n;
	mode_t mode_q;
	logic [7:0] node_q;
	logic [31:0] now_q;
	logic [15:0] ival_q;
	logic aon_q;
	logic [CNT_W-1:0] idx_q;
	logic found_q;
	logic [IDX_W-1:0] best_q;
	logic [31:0] best_ls_q;
	logic best_v_q;
	logic noent_q;
	event_t ev_q;
	logic [31:0] base_q;

	// Pending lost event of a scan.
	logic pend_v_q;
	logic [85:0] pend_q;

	// Output register.
	logic out_v_q;
	logic [85:0] out_q;
	logic out_last_q;

	logic [IDX_W-1:0] ix;
	logic [7:0] rd_node;
	logic [31:0] rd_ls, rd_cycle, rd_to, rd_eff;
	logic [10:0] rd_ival;
	logic rd_act, rd_aon;
	logic in_acc, out_free, at_end, hit, lost;
	logic [31:0] gap;
	logic learn, have_room;
	logic [DIV_W-1:0] div_num;
	logic div_start;
	div_rsp_t div_rsp;
	logic [31:0] delta;
	logic [32:0] tsum;
	logic [85:0] rd_pack;
	logic [1:0] in_mode;
	logic bad_item;
	logic [IDX_W-1:0] new_slot;
	logic out_load;

	assign ix = idx_q[IDX_W-1:0];
	assign rd_node = e_node_q[ix];
	assign rd_ls = e_ls_q[ix];
	assign rd_ival = e_ival_q[ix];
	assign rd_cycle = e_cycle_q[ix];
	assign rd_to = e_to_q[ix];
	assign rd_act = e_act_q[ix];
	assign rd_aon = e_aon_q[ix];
	assign rd_eff = (rd_to != '0) ? rd_to : default_to_q;

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;
	assign at_end = (idx_q == used_q);
	assign hit = !at_end && (rd_node == node_q);
	assign gap = now_q - rd_ls;
	assign lost = !at_end && rd_act && ((now_q - rd_ls) > rd_eff);
	assign learn = rd_act && (gap > min_gap_q);
	assign have_room = (used_q != CNT_W'(TABLE_DEPTH));
	assign new_slot = have_room ? used_q[IDX_W-1:0] : best_q;
	assign div_num = ({4'b0, rd_cycle} << 3) - {4'b0, rd_cycle} +
		({4'b0, gap} << 1) + {4'b0, gap};
	assign div_start = (state_q == S_DECIDE) && found_q && (mode_q == MODE_HEARD) &&
		learn && (rd_cycle != '0);
	assign rd_pack = {rd_cycle, rd_ival, rd_eff, EV_LOST, rd_node};

	// A result enters the output register in these cases.
	assign out_load = out_free && ((state_q == S_RESULT) ||
		(state_q == S_SCAN && lost && pend_v_q) ||
		(state_q == S_SCAN_END && pend_v_q));

	// Gateway items, interval items for node 255 and out-of-range intervals are refused on arrival.
	assign in_mode = s_tuser;
	assign bad_item = (in_mode != MODE_SCAN && s_tdata[7:0] == 8'd0) ||
		(in_mode == MODE_INTERVAL && (s_tdata[7:0] == 8'd255 ||
		s_tdata[55:40] < {5'b0, min_ival_q} || s_tdata[55:40] > {5'b0, max_ival_q}));

	// Timeout margin and sum for the last recompute step.
	assign delta = ((base_q >> 1) < MIN_MARGIN_MS) ? MIN_MARGIN_MS : (base_q >> 1);
	assign tsum = {1'b0, base_q} + {1'b0, delta};

	nlt_div10 u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.rsp   (div_rsp)
	);

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_mode == MODE_SCAN) state_n = S_SCAN;
					else if (bad_item) state_n = S_RESULT;
					else state_n = S_SEARCH;
				end
			end
			S_SEARCH: if (at_end || hit) state_n = S_DECIDE;
			S_DECIDE: begin
				if (mode_q == MODE_HEARD) begin
					if (found_q && learn) state_n = (rd_cycle != '0) ? S_DIV : S_REC1;
					else state_n = S_RESULT;
				end else if (mode_q == MODE_INTERVAL) begin
					state_n = found_q ? S_REC1 : S_RESULT;
				end else begin
					state_n = (found_q || have_room || best_v_q) ? S_REC1 : S_RESULT;
				end
			end
			S_DIV: if (div_rsp.done) state_n = S_REC1;
			S_REC1: state_n = S_REC2;
			S_REC2: state_n = S_REC3;
			S_REC3: state_n = S_REC4;
			S_REC4: state_n = S_RESULT;
			S_RESULT: if (out_free) state_n = S_IDLE;
			S_SCAN: if (at_end) state_n = S_SCAN_END;
			S_SCAN_END: if (!pend_v_q || out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_to_q <= 32'd900000;
			min_ival_q <= 11'd1;
			max_ival_q <= 11'd1440;
			max_to_q <= 32'd86400000;
			min_gap_q <= 32'd5000;
			stale_q <= 5'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEFAULT_TIMEOUT: default_to_q <= cfg_data;
				CFG_MIN_INTERVAL: min_ival_q <= cfg_data[10:0];
				CFG_MAX_INTERVAL: max_ival_q <= cfg_data[10:0];
				CFG_MAX_TIMEOUT: max_to_q <= cfg_data;
				CFG_MIN_GAP: min_gap_q <= cfg_data;
				CFG_STALE_FACTOR: stale_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Sequencer datapath, entry writes and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				e_node_q[i] <= '0;
				e_ls_q[i] <= '0;
				e_ival_q[i] <= '0;
				e_cycle_q[i] <= '0;
				e_to_q[i] <= '0;
				e_act_q[i] <= 1'b0;
				e_aon_q[i] <= 1'b0;
			end
			used_q <= '0;
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			best_v_q <= 1'b0;
			noent_q <= 1'b0;
			mode_q <= MODE_HEARD;
			ev_q <= EV_OK;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q <= mode_t'(in_mode);
						node_q <= s_tdata[7:0];
						now_q <= s_tdata[39:8];
						ival_q <= s_tdata[55:40];
						aon_q <= s_tdata[56];
						idx_q <= '0;
						found_q <= 1'b0;
						best_v_q <= 1'b0;
						noent_q <= bad_item;
						ev_q <= EV_IGNORED;
						pend_v_q <= 1'b0;
					end
				end
				S_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
					end else if (!at_end) begin
						// Oldest inactive entry, ties to the lowest index.
						if (!rd_act && (!best_v_q || rd_ls < best_ls_q)) begin
							best_v_q <= 1'b1;
							best_q <= ix;
							best_ls_q <= rd_ls;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DECIDE: begin
					if (found_q) begin
						case (mode_q)
							MODE_HEARD: begin
								ev_q <= rd_act ? EV_OK : EV_BACK;
								if (learn && rd_cycle == '0) e_cycle_q[ix] <= gap;
								e_ls_q[ix] <= now_q;
								e_act_q[ix] <= 1'b1;
							end
							MODE_INTERVAL: begin
								ev_q <= EV_OK;
								e_ival_q[ix] <= ival_q[10:0];
							end
							default: begin
								ev_q <= EV_OK;
								e_aon_q[ix] <= aon_q;
								e_ls_q[ix] <= now_q;
								e_act_q[ix] <= 1'b1;
							end
						endcase
					end else if (mode_q == MODE_INTERVAL) begin
						noent_q <= 1'b1;
						ev_q <= EV_IGNORED;
					end else if (have_room || best_v_q) begin
						// New entry at the end of the table or over an evicted one.
						if (have_room) used_q <= used_q + 1'b1;
						idx_q <= {{(CNT_W-IDX_W){1'b0}}, new_slot};
						e_node_q[new_slot] <= node_q;
						e_ls_q[new_slot] <= now_q;
						e_ival_q[new_slot] <= '0;
						e_cycle_q[new_slot] <= '0;
						e_to_q[new_slot] <= '0;
						e_act_q[new_slot] <= 1'b1;
						e_aon_q[new_slot] <= (mode_q == MODE_PROFILE) ? aon_q : 1'b0;
						ev_q <= EV_ADDED;
					end else begin
						noent_q <= 1'b1;
						ev_q <= EV_FULL;
					end
				end
				S_DIV: if (div_rsp.done) e_cycle_q[ix] <= div_rsp.quo;
				S_REC1: base_q <= 32'({5'b0, rd_ival} * MS_PER_MIN);
				S_REC2: if (base_q != '0 && rd_aon) base_q <= 32'(base_q * stale_q);
				S_REC3: if (rd_cycle > base_q) base_q <= rd_cycle;
				S_REC4: begin
					if (base_q == '0) e_to_q[ix] <= '0;
					else if (tsum > {1'b0, max_to_q}) e_to_q[ix] <= max_to_q;
					else e_to_q[ix] <= tsum[31:0];
				end
				S_RESULT: begin
					if (out_free) begin
						out_last_q <= 1'b1;
						if (noent_q) out_q <= {75'b0, ev_q, node_q};
						else out_q <= {rd_cycle, rd_ival, rd_eff, ev_q, node_q};
					end
				end
				S_SCAN: begin
					if (lost) begin
						if (!pend_v_q || out_free) begin
							e_act_q[ix] <= 1'b0;
							if (pend_v_q) begin
								out_q <= pend_q;
								out_last_q <= 1'b0;
							end
							pend_v_q <= 1'b1;
							pend_q <= rd_pack;
							idx_q <= idx_q + 1'b1;
						end
					end else if (!at_end) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN_END: begin
					if (pend_v_q && out_free) begin
						out_q <= pend_q;
						out_last_q <= 1'b1;
						pend_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {2'b0, out_q};
	assign m_tlast = out_last_q;

`ifndef SYNTHESIS
	// The divider only runs while an item is in progress.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_rsp.busy)
		else $error("divider busy while idle");
	// The fill count never passes the table depth.
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond depth");
	// An accepted item always takes the block out of idle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("ready right after accept");
	// A pending scan event exists only during a scan.
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == S_SCAN || state_q == S_SCAN_END))
		else $error("pending event outside scan");
`endif

endmodule
`default_nettype wire

// File: sv/nlt_div10.sv
// Divide-by-ten unit built from shifts and adds, one step per cycle.
`default_nettype none
module nlt_div10 (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [nlt_pkg::DIV_W-1:0] num,
	output nlt_pkg::div_rsp_t        rsp
);
	import nlt_pkg::*;

	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] quo_q;
	logic [5:0] step_q;
	logic done_q;
	logic [DIV_W-1:0] rem;

	// Remainder of the estimate; the last step rounds the quotient up by one if needed.
	assign rem = num_q - ((quo_q << 3) + (quo_q << 1));

	// One step marker per cycle; the last step raises done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			step_q <= {step_q[4:0], start};
			done_q <= step_q[5];
		end
	end

	// Estimate of 0.8 times the numerator, refined by shifted sums, divided by eight, then corrected.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			quo_q <= (num >> 1) + (num >> 2);
		end else if (step_q[0]) begin
			quo_q <= quo_q + (quo_q >> 4);
		end else if (step_q[1]) begin
			quo_q <= quo_q + (quo_q >> 8);
		end else if (step_q[2]) begin
			quo_q <= quo_q + (quo_q >> 16);
		end else if (step_q[3]) begin
			quo_q <= quo_q + (quo_q >> 32);
		end else if (step_q[4]) begin
			quo_q <= quo_q >> 3;
		end else if (step_q[5]) begin
			quo_q <= quo_q + DIV_W'(rem >= DIV_W'(DIV_TEN));
		end
	end

	assign rsp.busy = |step_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q[31:0];

endmodule
`default_nettype wire
